// File: hdl/vlpd_pkg.sv
// Package for the varint length-prefix deframer: shared constants, codes and types.
// Depends on nothing; used by every module under hdl.
package vlpd_pkg;

	localparam int unsigned MAX_PREFIX_BYTES_DEF = 5;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 31;
	localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RST = 31'd2097151;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic REG_MAX_FRAME_LEN = 1'b0;

	localparam logic [BYTE_W-1:0] VARINT_DATA_MASK = 8'h7F;
	localparam int unsigned VARINT_MORE_BIT = 7;
	localparam int unsigned VARINT_DIGIT_W = 7;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_ZERO_LEN = 2'd1,
		ERR_TOO_LONG = 2'd2,
		ERR_OVERLONG = 2'd3
	} err_code_t;

	typedef struct packed {
		logic      frame_first;
		logic      frame_last;
		logic      is_prefix;
		err_code_t error_code;
	} byte_flags_t;

endpackage

// File: hdl/vlpd_cfg_regs.sv
// APB-style configuration register block holding the frame length limit.
// Depends on vlpd_pkg.
module vlpd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vlpd_pkg::PADDR_W-1:0]  paddr,
	input  logic [vlpd_pkg::PDATA_W-1:0]  pwdata,
	output logic [vlpd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [vlpd_pkg::LEN_W-1:0]    max_frame_len
);
	import vlpd_pkg::*;

	logic [LEN_W-1:0] max_frame_len_q;
	logic             hit_max_len;

	// Registers sit on 4-byte boundaries, so bit 2 selects the register.
	assign hit_max_len = (paddr[PADDR_W-1] == REG_MAX_FRAME_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= MAX_FRAME_LEN_RST;
		end else if (psel && penable && pwrite && pready && hit_max_len) begin
			max_frame_len_q <= pwdata[LEN_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = hit_max_len ? {{(PDATA_W-LEN_W){1'b0}}, max_frame_len_q} : '0;
	assign max_frame_len = max_frame_len_q;

endmodule

// File: hdl/vlpd_parse.sv
// Next-state and flag logic for one byte of the deframer.
// Purely combinational; depends on vlpd_pkg.
module vlpd_parse #(
	parameter int unsigned MAX_PREFIX_BYTES = vlpd_pkg::MAX_PREFIX_BYTES_DEF,
	localparam int unsigned ACC_W = 7 * MAX_PREFIX_BYTES,
	localparam int unsigned CNT_W = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1
) (
	input  logic [vlpd_pkg::BYTE_W-1:0] data_byte,
	input  logic [vlpd_pkg::LEN_W-1:0]  max_frame_len,
	input  logic                        in_payload,
	input  logic [ACC_W-1:0]            length_accum,
	input  logic [CNT_W-1:0]            prefix_count,
	input  logic [vlpd_pkg::LEN_W-1:0]  bytes_left,
	output logic                        in_payload_nxt,
	output logic [ACC_W-1:0]            length_accum_nxt,
	output logic [CNT_W-1:0]            prefix_count_nxt,
	output logic [vlpd_pkg::LEN_W-1:0]  bytes_left_nxt,
	output vlpd_pkg::byte_flags_t       flags
);
	import vlpd_pkg::*;

	localparam int unsigned CMP_W = (ACC_W > LEN_W) ? ACC_W : LEN_W;
	localparam int unsigned SH_W = $clog2(ACC_W);
	localparam int unsigned CNT_EXT_W = CNT_W + 1;

	logic [ACC_W-1:0]     digit;
	logic [ACC_W-1:0]     acc_new;
	logic [CMP_W-1:0]     len_cmp;
	logic [CMP_W-1:0]     lim_cmp;
	logic [SH_W-1:0]      shift;
	logic [CNT_EXT_W-1:0] cnt_inc;
	logic                 more;

	assign digit   = ACC_W'(data_byte & VARINT_DATA_MASK);
	assign shift   = SH_W'(prefix_count * VARINT_DIGIT_W);
	assign acc_new = length_accum | (digit << shift);
	assign len_cmp = CMP_W'(acc_new);
	assign lim_cmp = CMP_W'(max_frame_len);
	assign cnt_inc = CNT_EXT_W'(prefix_count) + CNT_EXT_W'(1);
	assign more    = data_byte[VARINT_MORE_BIT];

	always_comb begin
		in_payload_nxt   = in_payload;
		length_accum_nxt = length_accum;
		prefix_count_nxt = prefix_count;
		bytes_left_nxt   = bytes_left;
		flags            = '{frame_first: 1'b0, frame_last: 1'b0, is_prefix: 1'b0,
			error_code: ERR_NONE};
		if (in_payload) begin
			bytes_left_nxt = bytes_left - LEN_W'(1);
			if (bytes_left == LEN_W'(1)) begin
				flags.frame_last = 1'b1;
				in_payload_nxt   = 1'b0;
			end
		end else begin
			flags.is_prefix   = 1'b1;
			flags.frame_first = (prefix_count == '0);
			length_accum_nxt  = '0;
			prefix_count_nxt  = '0;
			if (more) begin
				if (cnt_inc >= CNT_EXT_W'(MAX_PREFIX_BYTES)) begin
					flags.error_code = ERR_OVERLONG;
				end else begin
					length_accum_nxt = acc_new;
					prefix_count_nxt = cnt_inc[CNT_W-1:0];
				end
			end else if (acc_new == '0) begin
				flags.error_code = ERR_ZERO_LEN;
			end else if (len_cmp > lim_cmp) begin
				flags.error_code = ERR_TOO_LONG;
			end else begin
				// The length fits the limit, so it fits the counter.
				bytes_left_nxt = acc_new[LEN_W-1:0];
				in_payload_nxt = 1'b1;
			end
		end
	end

endmodule

// File: hdl/varint_length_prefix_deframer_core.sv
// Channel   | Signals                                    | Direction
// ----------+--------------------------------------------+----------
// input     | in_valid, in_ready, data_byte              | in
// output    | out_valid, out_ready, out_byte, frame_*    | out
//           | is_prefix, error_code                      |
// config    | psel, penable, pwrite, paddr, pwdata,      | in/out
//           | prdata, pready                             |
//
// One byte per cycle unless the output stalls: each accepted request is parsed
// in the cycle it is taken and its result lands in the output register on that edge.
// A new request is taken whenever the output register is empty or being read.
// Output stalls hold the result register and the frame state; nothing is lost.
// Reset clears the frame state and sets the length limit to 2097151.
// Depends on vlpd_pkg, vlpd_cfg_regs and vlpd_parse.
module varint_length_prefix_deframer_core #(
	parameter int unsigned MAX_PREFIX_BYTES = vlpd_pkg::MAX_PREFIX_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vlpd_pkg::BYTE_W-1:0]   data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vlpd_pkg::BYTE_W-1:0]   out_byte,
	output logic                          frame_first,
	output logic                          frame_last,
	output logic                          is_prefix,
	output logic [1:0]                    error_code,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vlpd_pkg::PADDR_W-1:0]  paddr,
	input  logic [vlpd_pkg::PDATA_W-1:0]  pwdata,
	output logic [vlpd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import vlpd_pkg::*;

	localparam int unsigned ACC_W = 7 * MAX_PREFIX_BYTES;
	localparam int unsigned CNT_W = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1;

	logic [LEN_W-1:0]  max_frame_len;
	logic              in_payload_q;
	logic [ACC_W-1:0]  length_accum_q;
	logic [CNT_W-1:0]  prefix_count_q;
	logic [LEN_W-1:0]  bytes_left_q;
	logic              in_payload_nxt;
	logic [ACC_W-1:0]  length_accum_nxt;
	logic [CNT_W-1:0]  prefix_count_nxt;
	logic [LEN_W-1:0]  bytes_left_nxt;
	byte_flags_t       flags;
	byte_flags_t       flags_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s1;
	logic              take;

	vlpd_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.max_frame_len (max_frame_len)
	);

	vlpd_parse #(
		.MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
	) u_parse (
		.data_byte        (data_byte),
		.max_frame_len    (max_frame_len),
		.in_payload       (in_payload_q),
		.length_accum     (length_accum_q),
		.prefix_count     (prefix_count_q),
		.bytes_left       (bytes_left_q),
		.in_payload_nxt   (in_payload_nxt),
		.length_accum_nxt (length_accum_nxt),
		.prefix_count_nxt (prefix_count_nxt),
		.bytes_left_nxt   (bytes_left_nxt),
		.flags            (flags)
	);

	assign in_ready = !valid_s1 || out_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q   <= 1'b0;
			length_accum_q <= '0;
			prefix_count_q <= '0;
			bytes_left_q   <= '0;
			valid_s1       <= 1'b0;
		end else begin
			if (take) begin
				in_payload_q   <= in_payload_nxt;
				length_accum_q <= length_accum_nxt;
				prefix_count_q <= prefix_count_nxt;
				bytes_left_q   <= bytes_left_nxt;
				valid_s1       <= 1'b1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1  <= data_byte;
			flags_s1 <= flags;
		end
	end

	assign out_valid   = valid_s1;
	assign out_byte    = byte_s1;
	assign frame_first = flags_s1.frame_first;
	assign frame_last  = flags_s1.frame_last;
	assign is_prefix   = flags_s1.is_prefix;
	assign error_code  = flags_s1.error_code;

endmodule
